### src/lpm_pkg.sv
// Package for the longest-prefix-match forwarding table.
// Holds the item kinds, status codes, register indexes, controller states,
// the structs passed along the cell chain and the mask helper functions.
`default_nettype none

package lpm_pkg;

  localparam int LPM_TABLE_DEPTH = 64;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DUP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_VALID     = 2'd0,
    REG_DEFAULT_INTERFACE = 2'd1,
    REG_DEFAULT_NEXT_HOP  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOAD   = 2'd1,
    S_SCAN   = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  // Token that walks the cell chain, gathering the search outcome.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [31:0] pfx;
    logic        best_found;
    logic [5:0]  best_len;
    logic [7:0]  best_ifc;
    logic [31:0] best_nh;
    logic        dup;
    logic        free_found;
  } token_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic        commit_add;
    logic        clear_all;
    logic [31:0] pfx;
    logic [5:0]  len;
    logic [7:0]  ifc;
    logic [31:0] nh;
  } bcast_t;

  function automatic logic [31:0] mask_of(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

  // Keeps only the run of ones at the top of the mask.
  function automatic logic [31:0] leading_mask(input logic [31:0] m);
    logic [31:0] z;
    z = ~m;
    z = z | (z >> 1);
    z = z | (z >> 2);
    z = z | (z >> 4);
    z = z | (z >> 8);
    z = z | (z >> 16);
    return ~z;
  endfunction

endpackage

`default_nettype wire

### src/longest_prefix_match_table.sv
// Top level of the longest-prefix-match forwarding table.
// Depends on lpm_pkg and lpm_cell; holds the controller, registers and result stage.
//
//   Channel  Direction  Handshake          Content
//   s_       in         s_tvalid/s_tready  kind in tuser; route and address in tdata
//   m_       out        m_tvalid/m_tready  hit, route_valid, status in tuser; route in tdata
//   cfg_     in         cfg_write          default route registers
//
// One item is handled at a time: it walks the chain of TABLE_DEPTH cells, one cell
// a cycle, and the next item is taken only once the previous result has been loaded
// into the output register.
// Reset clears every entry's valid bit at once; no clearing pass is needed.
// A stalled result holds in the output register while one further item is taken and
// searched; that item then waits in the finish state, holding off the input, until it goes.
`default_nettype none

module longest_prefix_match_table
  import lpm_pkg::*;
#(
  parameter int TABLE_DEPTH = LPM_TABLE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [103:0] s_tdata,  // address, netmask, interface_in, next_hop_in
  input  wire logic [1:0]   s_tuser,  // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,  // interface_out, next_hop_out
  output logic [3:0]        m_tuser,  // hit, route_valid, status
  input  wire logic         cfg_write,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic        default_valid;
  logic [7:0]  default_interface;
  logic [31:0] default_next_hop;

  kind_t       item_kind;
  logic [31:0] item_addr;
  logic [31:0] item_mask;
  logic [7:0]  item_ifc;
  logic [31:0] item_nh;

  token_t tok [TABLE_DEPTH+1];
  token_t done_tok;
  bcast_t bc;

  logic [TABLE_DEPTH-1:0] pending_vec;
  logic [TABLE_DEPTH-1:0] tok_valid_vec;

  logic        out_free;
  logic        load_out;
  logic        res_hit;
  logic        res_rv;
  logic [7:0]  res_ifc;
  logic [31:0] res_nh;
  status_t     res_status;
  logic [31:0] keep;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      lpm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok[g]),
        .bc      (bc),
        .tok_out (tok[g+1]),
        .pending (pending_vec[g])
      );
      assign tok_valid_vec[g] = tok[g+1].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      default_valid     <= 1'b0;
      default_interface <= 8'd0;
      default_next_hop  <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEFAULT_VALID:     default_valid     <= cfg_data[0];
        REG_DEFAULT_INTERFACE: default_interface <= cfg_data[7:0];
        REG_DEFAULT_NEXT_HOP:  default_next_hop  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_LOAD;
      S_LOAD:   state_next = S_SCAN;
      S_SCAN:   if (tok[TABLE_DEPTH].valid) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_free = !m_tvalid || m_tready;
    s_tready = (state == S_IDLE);
    load_out = (state == S_FINISH) && out_free;

    keep = leading_mask(item_mask);
    tok[0]            = '0;
    tok[0].valid      = (state == S_LOAD);
    tok[0].kind       = item_kind;
    tok[0].addr       = item_addr;
    tok[0].len        = 6'($countones(keep));
    tok[0].pfx        = item_addr & keep;

    bc.commit_add = load_out && (done_tok.kind == KIND_ADD) && !done_tok.dup &&
                    done_tok.free_found;
    bc.clear_all  = load_out && (done_tok.kind == KIND_CLEAR);
    bc.pfx        = done_tok.pfx;
    bc.len        = done_tok.len;
    bc.ifc        = item_ifc;
    bc.nh         = item_nh;

    res_hit    = 1'b0;
    res_rv     = 1'b0;
    res_ifc    = 8'd0;
    res_nh     = 32'd0;
    res_status = STATUS_DONE;
    case (done_tok.kind)
      KIND_LOOKUP: begin
        if (done_tok.best_found) begin
          res_hit = 1'b1;
          res_rv  = 1'b1;
          res_ifc = done_tok.best_ifc;
          res_nh  = done_tok.best_nh;
        end else if (default_valid) begin
          res_rv  = 1'b1;
          res_ifc = default_interface;
          res_nh  = default_next_hop;
        end
      end
      KIND_ADD: begin
        if (done_tok.dup) begin
          res_status = STATUS_DUP;
        end else if (!done_tok.free_found) begin
          res_status = STATUS_FULL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_kind <= kind_t'(s_tuser);
      item_addr <= s_tdata[31:0];
      item_mask <= s_tdata[63:32];
      item_ifc  <= s_tdata[71:64];
      item_nh   <= s_tdata[103:72];
    end
    if (state == S_SCAN && tok[TABLE_DEPTH].valid) begin
      done_tok <= tok[TABLE_DEPTH];
    end
    if (load_out) begin
      m_tdata <= {res_nh, res_ifc};
      m_tuser <= {res_status, res_rv, res_hit};
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid_vec))
    else $error("More than one item in the cell chain.");

  a_single_claim: assert property (@(posedge clk) disable iff (rst)
    bc.commit_add |-> $onehot(pending_vec))
    else $error("Route commit without exactly one claimed cell.");

  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[TABLE_DEPTH].valid |-> (state == S_SCAN))
    else $error("Item left the cell chain outside the scan state.");

endmodule

`default_nettype wire

### src/lpm_cell.sv
// One entry of the forwarding table as a cell of the search chain.
// Depends on lpm_pkg for the token and broadcast structs and mask_of.
`default_nettype none

module lpm_cell
  import lpm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire token_t tok_in,
  input  wire bcast_t bc,
  output token_t      tok_out,
  output logic        pending
);

  logic        valid;
  logic [31:0] prefix;
  logic [5:0]  length;
  logic [7:0]  ifc;
  logic [31:0] nh;

  logic   match;
  logic   better;
  logic   is_dup;
  logic   claim;
  token_t tok_next;

  always_comb begin
    match    = valid && ((tok_in.addr & mask_of(length)) == prefix);
    better   = match && (!tok_in.best_found || (length > tok_in.best_len));
    is_dup   = valid && (length == tok_in.len) && (prefix == tok_in.pfx);
    claim    = tok_in.valid && (tok_in.kind == KIND_ADD) && !valid && !tok_in.free_found;
    tok_next = tok_in;
    if (tok_in.kind == KIND_LOOKUP && better) begin
      tok_next.best_found = 1'b1;
      tok_next.best_len   = length;
      tok_next.best_ifc   = ifc;
      tok_next.best_nh    = nh;
    end
    if (tok_in.kind == KIND_ADD) begin
      tok_next.dup        = tok_in.dup | is_dup;
      tok_next.free_found = tok_in.free_found | !valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pending <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (bc.clear_all) begin
        valid <= 1'b0;
      end
      if (bc.commit_add) begin
        pending <= 1'b0;
        if (pending) begin
          valid <= 1'b1;
        end
      end
      if (tok_in.valid) begin
        pending <= claim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bc.commit_add && pending) begin
      prefix <= bc.pfx;
      length <= bc.len;
      ifc    <= bc.ifc;
      nh     <= bc.nh;
    end
  end

endmodule

`default_nettype wire
